[src/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the SPI master byte engine.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int SS_LINES   = 8;
  localparam int FRAME_BITS = 8;
  localparam int EDGE_LAST  = 2 * FRAME_BITS;

  localparam int SS_W    = 3;
  localparam int EDGE_W  = 5;
  localparam int TICK_W  = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_POLARITY = 2'd0;
  localparam logic [1:0] REG_PHASE    = 2'd1;
  localparam logic [1:0] REG_HALF     = 2'd2;

  // Input item codes.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic              polarity;
    logic              phase;
    logic [TICK_W-1:0] half_period;
  } spm_cfg_t;

  typedef struct packed {
    logic [EDGE_W-1:0]     edge_count;
    logic [TICK_W-1:0]     tick_count;
    logic [FRAME_BITS-1:0] tx_shadow;
    logic [FRAME_BITS-1:0] rx_shift;
    logic [SS_W-1:0]       ss_latched;
    logic                  active;
    logic                  sclk;
    logic                  mosi;
  } spm_state_t;

  typedef struct packed {
    logic                  sclk_level;
    logic                  mosi_level;
    logic [SS_W-1:0]       ss_index;
    logic                  ss_active;
    logic                  busy_res;
    logic                  done_res;
    logic [FRAME_BITS-1:0] rx_byte;
  } spm_result_t;

endpackage

[src/spm_step.sv]
// ----------------------------------------------------------------------------
// spm_step
// Next-state logic for one beat: start, divider tick, clock edge and stop.
// ----------------------------------------------------------------------------
module spm_step (
  input  spm_pkg::spm_cfg_t                cfg,
  input  spm_pkg::spm_state_t              cur,
  input  logic                             func,
  input  logic [spm_pkg::FRAME_BITS-1:0]   tx_byte,
  input  logic [spm_pkg::SS_W-1:0]         ss_select,
  input  logic                             miso_level,
  output spm_pkg::spm_state_t              nxt,
  output logic                             done
);

  logic [spm_pkg::TICK_W-1:0] hp;
  logic [spm_pkg::TICK_W:0]   tick_inc;
  logic                       expire;
  logic [spm_pkg::EDGE_W-1:0] edge_inc;
  logic [3:0]                 bit_idx;
  logic                       tx_bit;
  logic                       do_drive;
  logic [spm_pkg::SS_W-1:0]   ss_mod;

  assign hp       = (cfg.half_period == '0) ? spm_pkg::TICK_W'(1) : cfg.half_period;
  assign tick_inc = {1'b0, cur.tick_count} + (spm_pkg::TICK_W+1)'(1);
  assign expire   = tick_inc >= {1'b0, hp};
  assign edge_inc = cur.edge_count + spm_pkg::EDGE_W'(1);
  assign bit_idx  = edge_inc[4:1];
  assign tx_bit   = (bit_idx < 4'(spm_pkg::FRAME_BITS)) ? cur.tx_shadow[bit_idx[2:0]] : 1'b0;
  // Odd edges are leading edges; phase picks which edge drives MOSI.
  assign do_drive = edge_inc[0] ? cfg.phase : ~cfg.phase;
  assign ss_mod   = spm_pkg::SS_W'(32'(ss_select) % spm_pkg::SS_LINES);

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (func == spm_pkg::FUNC_START) begin
      if (!cur.active) begin
        nxt.tx_shadow  = tx_byte;
        nxt.ss_latched = ss_mod;
        nxt.rx_shift   = '0;
        nxt.edge_count = '0;
        nxt.tick_count = '0;
        nxt.active     = 1'b1;
        nxt.sclk       = cfg.polarity;
        nxt.mosi       = cfg.phase ? 1'b1 : tx_byte[0];
      end
    end else if (cur.active) begin
      if (expire) begin
        nxt.tick_count = '0;
        if (cur.edge_count >= spm_pkg::EDGE_W'(spm_pkg::EDGE_LAST)) begin
          nxt.active     = 1'b0;
          nxt.edge_count = '0;
          nxt.mosi       = 1'b1;
          nxt.sclk       = cfg.polarity;
          done           = 1'b1;
        end else begin
          nxt.edge_count = edge_inc;
          if (do_drive) begin
            nxt.mosi = tx_bit;
          end else begin
            nxt.rx_shift = {miso_level, cur.rx_shift[spm_pkg::FRAME_BITS-1:1]};
          end
          nxt.sclk = edge_inc[0] ? ~cfg.polarity : cfg.polarity;
        end
      end else begin
        nxt.tick_count = tick_inc[spm_pkg::TICK_W-1:0];
      end
    end
  end

endmodule

[src/spm_out_stage.sv]
// ----------------------------------------------------------------------------
// spm_out_stage
// Result register with valid/ready handshake; loads while the old beat leaves.
// ----------------------------------------------------------------------------
module spm_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  spm_pkg::spm_result_t load_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 can_load,
  output spm_pkg::spm_result_t out_data
);

  logic                 valid_r;
  logic                 valid_nxt;
  spm_pkg::spm_result_t data_r;

  assign can_load  = ~valid_r | out_ready;
  assign valid_nxt = load | (valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[src/spi_master_byte_engine_core.sv]
// ----------------------------------------------------------------------------
// spi_master_byte_engine_core
// SPI master moving one byte, least significant bit first, in modes 0 to 3.
// ----------------------------------------------------------------------------
// Every input beat is one step of the engine: a start beat (func = 1) latches
// the byte to send and the select index, a tick beat (func = 0) advances the
// half-period divider, and each divider expiry makes one serial clock edge.
// A transfer runs its clock edges, then the next expiry releases select and
// flags done. Each input beat yields exactly one result beat with the line
// levels after it. The block takes one beat per cycle while in_ready is high:
// the next state is computed in one pass from the state registers and the
// accepted beat, and written together with the result register at the same
// edge. in_ready drops only while the result register holds a beat that
// out_ready does not take. Configuration sits on an APB port (polarity at
// 0x0, phase at 0x4, half period at 0x8); write it only while no input beat
// is offered. A write during a transfer takes effect on the later edges of
// that transfer.
// ----------------------------------------------------------------------------
module spi_master_byte_engine_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [spm_pkg::ADDR_W-1:0]         paddr,
  input  logic [spm_pkg::DATA_W-1:0]         pwdata,
  output logic [spm_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [spm_pkg::FRAME_BITS-1:0]     in_tx_byte,
  input  logic [spm_pkg::SS_W-1:0]           in_ss_select,
  input  logic                               in_miso_level,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_sclk_level,
  output logic                               out_mosi_level,
  output logic [spm_pkg::SS_W-1:0]           out_ss_index,
  output logic                               out_ss_active,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic [spm_pkg::FRAME_BITS-1:0]     out_rx_byte
);

  // Configuration registers.
  spm_pkg::spm_cfg_t   cfg_r;
  spm_pkg::spm_cfg_t   cfg_nxt;
  // Engine state.
  spm_pkg::spm_state_t state_r;
  spm_pkg::spm_state_t state_nxt;
  spm_pkg::spm_state_t step_state;
  logic                step_done;
  logic                in_accept;
  logic                cfg_write;
  logic [1:0]          cfg_index;
  spm_pkg::spm_result_t result;
  spm_pkg::spm_result_t out_data;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = paddr[3:2];

  // Read back the addressed register; unused addresses read zero.
  always_comb begin
    case (cfg_index)
      spm_pkg::REG_POLARITY: prdata = {{(spm_pkg::DATA_W-1){1'b0}}, cfg_r.polarity};
      spm_pkg::REG_PHASE:    prdata = {{(spm_pkg::DATA_W-1){1'b0}}, cfg_r.phase};
      spm_pkg::REG_HALF:     prdata = {{(spm_pkg::DATA_W-spm_pkg::TICK_W){1'b0}},
                                       cfg_r.half_period};
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      case (cfg_index)
        spm_pkg::REG_POLARITY: cfg_nxt.polarity    = pwdata[0];
        spm_pkg::REG_PHASE:    cfg_nxt.phase       = pwdata[0];
        spm_pkg::REG_HALF:     cfg_nxt.half_period = pwdata[spm_pkg::TICK_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polarity    <= 1'b0;
      cfg_r.phase       <= 1'b0;
      cfg_r.half_period <= spm_pkg::TICK_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // One pass of next-state logic per accepted beat.
  spm_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .func       (in_func),
    .tx_byte    (in_tx_byte),
    .ss_select  (in_ss_select),
    .miso_level (in_miso_level),
    .nxt        (step_state),
    .done       (step_done)
  );

  assign in_accept = in_valid & in_ready;

  // Advance the state on an accepted beat. A polarity write while idle moves
  // the clock line to the new idle level at once; the user keeps config writes
  // and beats apart, which the block does not enforce: an accepted beat wins.
  always_comb begin
    state_nxt = state_r;
    if (in_accept) begin
      state_nxt = step_state;
    end else if (cfg_write && cfg_index == spm_pkg::REG_POLARITY && !state_r.active) begin
      state_nxt.sclk = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.edge_count <= '0;
      state_r.tick_count <= '0;
      state_r.tx_shadow  <= '0;
      state_r.rx_shift   <= '0;
      state_r.ss_latched <= '0;
      state_r.active     <= 1'b0;
      state_r.sclk       <= 1'b0;
      state_r.mosi       <= 1'b1;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Build the result beat from the state after this beat.
  always_comb begin
    result.sclk_level = step_state.sclk;
    result.mosi_level = step_state.mosi;
    result.ss_index   = step_state.ss_latched;
    result.ss_active  = step_state.active;
    result.busy_res   = step_state.active;
    result.done_res   = step_done;
    result.rx_byte    = step_state.rx_shift;
  end

  // Hold the result until taken; take the next beat in the same cycle.
  spm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .load_data (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .out_data  (out_data)
  );

  assign out_sclk_level = out_data.sclk_level;
  assign out_mosi_level = out_data.mosi_level;
  assign out_ss_index   = out_data.ss_index;
  assign out_ss_active  = out_data.ss_active;
  assign out_busy_res   = out_data.busy_res;
  assign out_done_res   = out_data.done_res;
  assign out_rx_byte    = out_data.rx_byte;

endmodule
